// ===== hw/rtl/top_k_sorted_score_list_macros.svh =====
// Assertion macros for the top-k sorted score list.
`ifndef TOP_K_SORTED_SCORE_LIST_MACROS_SVH
`define TOP_K_SORTED_SCORE_LIST_MACROS_SVH

`ifndef SYNTH
`define TKSL_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define TKSL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TKSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TKSL_ASSERT(label, cond)
`define TKSL_ASSERT_IMPL(label, ante, cons)
`define TKSL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/tksl_pkg.sv =====
// Shared types and constants for the top-k sorted score list.
`default_nettype none
package tksl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LIM_W    = (CNT_W > 7) ? CNT_W : 7;
  localparam int SCORE_W  = 32;
  localparam int HANDLE_W = 16;
  localparam int ENTRY_W  = SCORE_W + HANDLE_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_EVICT,
    ST_SHIFT,
    ST_PUT,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tksl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tksl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/top_k_sorted_score_list.sv =====
// Top level: sorted top-k (score, handle) list with insert, read and clear.
// Insert: one shift step per cycle over the RAM port.
// Read, clear and no-op each return one result word; commands are taken one at a time.
// A result word waits in the output register until taken.
// Synchronous active-low reset: list empty, max_entries 64; RAM not cleared.
`default_nettype none
`include "top_k_sorted_score_list_macros.svh"
module top_k_sorted_score_list (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // new_score, item_handle, read_index
  input  wire logic [1:0]  in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // accepted, slot, entry_count, read_valid,
                                       // read_score, read_handle
);

  localparam int IDX_W = tksl_pkg::IDX_W;
  localparam int CNT_W = tksl_pkg::CNT_W;
  localparam int LIM_W = tksl_pkg::LIM_W;

  tksl_pkg::state_t state_r, state_nxt;
  tksl_pkg::cmd_t   cmd_r, cmd_nxt;

  logic [6:0]              max_entries_r;
  logic signed [31:0]      score_r, score_nxt;
  logic [15:0]             handle_r, handle_nxt;
  logic [5:0]              ridx_r, ridx_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    acc_r, acc_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic                    rvalid_r, rvalid_nxt;
  logic [31:0]             rscore_r, rscore_nxt;
  logic [15:0]             rhandle_r, rhandle_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [63:0]             out_data_r, out_data_nxt;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [tksl_pkg::ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]        rd_addr;
  logic [tksl_pkg::ENTRY_W-1:0] rd_data;
  logic signed [31:0]      rd_score;

  logic [LIM_W-1:0]        me_ext;
  logic [CNT_W-1:0]        lim;
  logic [CNT_W-1:0]        lim_m1;

  tksl_ram #(
    .WIDTH (tksl_pkg::ENTRY_W),
    .DEPTH (tksl_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_score   = signed'(rd_data[31:0]);
  assign in_tready  = (state_r == tksl_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    me_ext = LIM_W'(max_entries_r);
    if (me_ext == '0) begin
      lim = CNT_W'(1);
    end else if (me_ext > LIM_W'(tksl_pkg::CAPACITY)) begin
      lim = CNT_W'(tksl_pkg::CAPACITY);
    end else begin
      lim = CNT_W'(me_ext);
    end
    lim_m1 = lim - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= 7'd64;
    end else if (cfg_wr_en) begin
      max_entries_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tksl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    score_r    <= score_nxt;
    handle_r   <= handle_nxt;
    ridx_r     <= ridx_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    slot_r     <= slot_nxt;
    rvalid_r   <= rvalid_nxt;
    rscore_r   <= rscore_nxt;
    rhandle_r  <= rhandle_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    score_nxt     = score_r;
    handle_nxt    = handle_r;
    ridx_nxt      = ridx_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    slot_nxt      = slot_r;
    rvalid_nxt    = rvalid_r;
    rscore_nxt    = rscore_r;
    rhandle_nxt   = rhandle_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = {handle_r, score_r};
    rd_addr       = '0;

    unique case (state_r)
      tksl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = tksl_pkg::cmd_t'(in_tuser[1:0]);
          score_nxt  = signed'(in_tdata[31:0]);
          handle_nxt = in_tdata[47:32];
          ridx_nxt   = in_tdata[53:48];
          state_nxt  = tksl_pkg::ST_START;
        end
      end

      tksl_pkg::ST_START: begin
        acc_nxt     = 1'b0;
        slot_nxt    = '0;
        rvalid_nxt  = 1'b0;
        rscore_nxt  = '0;
        rhandle_nxt = '0;
        unique case (cmd_r)
          tksl_pkg::CMD_INSERT: begin
            if (count_r >= lim) begin
              rd_addr   = IDX_W'(lim_m1);
              state_nxt = tksl_pkg::ST_EVICT;
            end else if (count_r == '0) begin
              k_nxt     = '0;
              n_nxt     = '0;
              state_nxt = tksl_pkg::ST_PUT;
            end else begin
              k_nxt     = IDX_W'(count_r);
              n_nxt     = IDX_W'(count_r);
              rd_addr   = IDX_W'(count_r - CNT_W'(1));
              state_nxt = tksl_pkg::ST_SHIFT;
            end
          end
          tksl_pkg::CMD_READ: begin
            if (LIM_W'(ridx_r) < LIM_W'(count_r)) begin
              rd_addr   = IDX_W'(ridx_r);
              state_nxt = tksl_pkg::ST_RDWAIT;
            end else begin
              state_nxt = tksl_pkg::ST_DONE;
            end
          end
          tksl_pkg::CMD_CLEAR: begin
            count_nxt = '0;
            state_nxt = tksl_pkg::ST_DONE;
          end
          tksl_pkg::CMD_NOP: begin
            state_nxt = tksl_pkg::ST_DONE;
          end
          default: begin
            state_nxt = tksl_pkg::ST_DONE;
          end
        endcase
      end

      // last retained entry is in rd_data
      tksl_pkg::ST_EVICT: begin
        if (score_r > rd_score) begin
          count_nxt = lim_m1;
          k_nxt     = IDX_W'(lim_m1);
          n_nxt     = IDX_W'(lim_m1);
          if (lim_m1 == '0) begin
            state_nxt = tksl_pkg::ST_PUT;
          end else begin
            rd_addr   = IDX_W'(lim_m1 - CNT_W'(1));
            state_nxt = tksl_pkg::ST_SHIFT;
          end
        end else begin
          state_nxt = tksl_pkg::ST_DONE;
        end
      end

      // rd_data holds entry k-1; move it down or place the new word at k
      tksl_pkg::ST_SHIFT: begin
        wr_en = 1'b1;
        if (rd_score > score_r) begin
          acc_nxt   = 1'b1;
          slot_nxt  = k_r;
          count_nxt = CNT_W'(n_r) + CNT_W'(1);
          state_nxt = tksl_pkg::ST_DONE;
        end else begin
          wr_data = rd_data;
          k_nxt   = k_r - IDX_W'(1);
          if (k_r == IDX_W'(1)) begin
            state_nxt = tksl_pkg::ST_PUT;
          end else begin
            rd_addr = k_r - IDX_W'(2);
          end
        end
      end

      tksl_pkg::ST_PUT: begin
        wr_en     = 1'b1;
        acc_nxt   = 1'b1;
        slot_nxt  = k_r;
        count_nxt = CNT_W'(n_r) + CNT_W'(1);
        state_nxt = tksl_pkg::ST_DONE;
      end

      tksl_pkg::ST_RDWAIT: begin
        rvalid_nxt  = 1'b1;
        rscore_nxt  = rd_data[31:0];
        rhandle_nxt = rd_data[47:32];
        state_nxt   = tksl_pkg::ST_DONE;
      end

      tksl_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, rhandle_r, rscore_r, rvalid_r,
                           7'(count_r), 6'(slot_r), acc_r};
          state_nxt     = tksl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tksl_pkg::ST_IDLE;
      end
    endcase
  end

  `TKSL_ASSERT(a_cnt_cap, count_r <= CNT_W'(tksl_pkg::CAPACITY))
  `TKSL_ASSERT_IMPL(a_shift_k, state_r == tksl_pkg::ST_SHIFT, k_r != '0)
  `TKSL_ASSERT_IMPL(a_wr_state, wr_en, state_r == tksl_pkg::ST_SHIFT || state_r == tksl_pkg::ST_PUT)
  `TKSL_ASSERT_IMPL(a_acc_cnt, state_r == tksl_pkg::ST_DONE && acc_r, count_r != '0)
  `TKSL_ASSERT_NEXT(a_put_done, state_r == tksl_pkg::ST_PUT, state_r == tksl_pkg::ST_DONE && acc_r)

endmodule
`default_nettype wire
